### hdl/kt_pkg.sv
`default_nettype none

package kt_pkg;

    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 64;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int S_RAW_W  = CMD_W + KEY_W + PAYLOAD_BITS;
    localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W  = STATUS_W + 1 + IDX_W + PAYLOAD_BITS + CNT_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic                    key_we;
        logic                    pay_we;
        logic [IDX_W-1:0]        addr;
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] pay;
    } kt_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } kt_state_t;

endpackage

`default_nettype wire

### hdl/kt_store.sv
`default_nettype none

module kt_store
    import kt_pkg::*;
(
    input  wire logic                    clk,
    input  wire kt_wr_t                  wr,
    input  wire logic [IDX_W-1:0]        rd_addr,
    output logic      [KEY_W-1:0]        rd_key,
    output logic      [PAYLOAD_BITS-1:0] rd_pay
);

    logic [KEY_W-1:0]        key_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        rd_key <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.pay_we)
        begin
            pay_mem[wr.addr] <= wr.pay;
        end
        rd_pay <= pay_mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/keyed_table_lazy_delete_compact_top.sv
`default_nettype none

// Keyed table of CAPACITY slots, each holding a key, a payload and a busy mark.
// A command item enters on the s_axis channel and exactly one result item leaves
// on the m_axis channel. Insert appends after the used slots, remove leaves a
// tombstone, lookup and update search the used slots in order, and compact
// moves the live entries down and shrinks the used count.
// One key and payload memory read port walks the used slots one per cycle,
// with one comparator checking each slot as it returns from the memory.
// Insert, remove, lookup and update stop the walk at the first hit, and
// compact walks every used slot. Undefined commands skip the walk and go
// straight to the result. s_axis_tready is low while a command is in progress.
// A finished result sits in the output register until it is taken; a new
// command is accepted meanwhile, and its result waits until the register frees.
// Reset clears the busy marks, the used count and the output valid at once;
// the key and payload memories are not cleared.
module keyed_table_lazy_delete_compact_top
    import kt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // Fields from bit 0: cmd, key, payload, zero fill.
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // Fields from bit 0: status, found, slot_index, payload_out, used_count, zero fill.
    output logic      [M_DATA_W-1:0] m_axis_tdata
);

    kt_state_t state_reg, state_next;

    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;

    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                busy_rd_reg, busy_rd_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [PAYLOAD_BITS-1:0] hit_pay_reg, hit_pay_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CAPACITY-1:0] busy_reg, busy_next;
    logic                out_vld_reg, out_vld_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    kt_wr_t                  wr;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    logic                    accept;
    logic                    issue;
    logic                    match;
    logic                    is_search;
    logic                    out_free;
    logic [STATUS_W-1:0]     res_status;
    logic                    res_found;
    logic [IDX_W-1:0]        res_slot;
    logic [PAYLOAD_BITS-1:0] res_pay;

    kt_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_key  (rd_key),
        .rd_pay  (rd_pay)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    assign is_search = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_REMOVE) ||
                       (cmd_reg == CMD_LOOKUP) || (cmd_reg == CMD_UPDATE);
    assign issue     = (state_reg == ST_SCAN) && (scan_reg < used_reg);
    assign match     = rd_vld_reg && busy_rd_reg && (rd_key == key_reg);
    assign out_free  = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        scan_next     = scan_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = scan_reg[IDX_W-1:0];
        busy_rd_next  = busy_reg[scan_reg[IDX_W-1:0]];
        live_next     = live_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_pay_next  = hit_pay_reg;
        used_next     = used_reg;
        busy_next     = busy_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        wr            = '0;
        res_status    = STAT_OK;
        res_found     = 1'b0;
        res_slot      = '0;
        res_pay       = '0;

        if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = s_axis_tdata[CMD_W-1:0];
                    key_next  = s_axis_tdata[CMD_W +: KEY_W];
                    pay_next  = s_axis_tdata[CMD_W+KEY_W +: PAYLOAD_BITS];
                    scan_next = '0;
                    live_next = '0;
                    hit_next  = 1'b0;
                    if (s_axis_tdata[CMD_W-1:0] <= CMD_COMPACT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                rd_vld_next = issue;
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (is_search && match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                    hit_pay_next = rd_pay;
                    state_next   = ST_FINISH;
                end
                else if (!issue && !rd_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
                if (!is_search && rd_vld_reg && busy_rd_reg)
                begin
                    wr.key_we = 1'b1;
                    wr.pay_we = 1'b1;
                    wr.addr   = live_reg[IDX_W-1:0];
                    wr.key    = rd_key;
                    wr.pay    = rd_pay;
                    live_next = live_reg + 1'b1;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_found = hit_reg;
                    res_slot  = hit_reg ? hit_idx_reg : '0;
                    priority if (cmd_reg == CMD_INSERT)
                    begin
                        if (hit_reg)
                        begin
                            res_status = STAT_DUPLICATE;
                        end
                        else if (used_reg == CNT_W'(CAPACITY))
                        begin
                            res_status = STAT_FULL;
                        end
                        else
                        begin
                            wr.key_we = 1'b1;
                            wr.pay_we = 1'b1;
                            wr.addr   = used_reg[IDX_W-1:0];
                            wr.key    = key_reg;
                            wr.pay    = pay_reg;
                            busy_next[used_reg[IDX_W-1:0]] = 1'b1;
                            res_slot  = used_reg[IDX_W-1:0];
                            used_next = used_reg + 1'b1;
                        end
                    end
                    else if (cmd_reg == CMD_REMOVE || cmd_reg == CMD_LOOKUP ||
                             cmd_reg == CMD_UPDATE)
                    begin
                        if (!hit_reg)
                        begin
                            res_status = STAT_NOT_FOUND;
                        end
                        else if (cmd_reg == CMD_REMOVE)
                        begin
                            busy_next[hit_idx_reg] = 1'b0;
                        end
                        else if (cmd_reg == CMD_LOOKUP)
                        begin
                            res_pay = hit_pay_reg;
                        end
                        else
                        begin
                            wr.pay_we = 1'b1;
                            wr.addr   = hit_idx_reg;
                            wr.pay    = pay_reg;
                        end
                    end
                    else if (cmd_reg == CMD_COMPACT)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            busy_next[i] = (CNT_W'(i) < live_reg);
                        end
                        used_next = live_reg;
                    end
                    else
                    begin
                        res_found = 1'b0;
                    end
                    out_vld_next  = 1'b1;
                    out_data_next = M_DATA_W'({used_next, res_pay, res_slot,
                                               res_found, res_status});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            used_reg    <= '0;
            busy_reg    <= '0;
            out_vld_reg <= 1'b0;
            scan_reg    <= '0;
            live_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            hit_reg     <= hit_next;
            used_reg    <= used_next;
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
            scan_reg    <= scan_next;
            live_reg    <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        rd_idx_reg   <= rd_idx_next;
        busy_rd_reg  <= busy_rd_next;
        hit_idx_reg  <= hit_idx_next;
        hit_pay_reg  <= hit_pay_next;
        out_data_reg <= out_data_next;
    end

    // The used count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(CAPACITY))
        else $error("used count above capacity");

    // No slot at or above the used count is ever marked busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg >> used_reg) == '0)
        else $error("busy mark above used slots");

    // While compacting, the write position never overtakes the read position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (live_reg <= scan_reg))
        else $error("compaction write ahead of read");

    // A result is only produced when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_axis_tready) |=> (out_vld_reg && $stable(out_data_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### tb/tb_keyed_table_lazy_delete_compact_top.sv
`timescale 1ns / 100ps

module tb_keyed_table_lazy_delete_compact_top;
    import kt_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0]        used;
        logic [PAYLOAD_BITS-1:0] pay;
        logic [IDX_W-1:0]        slot;
        logic                    found;
        logic [STATUS_W-1:0]     status;
    } table_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;

    logic [KEY_W-1:0]        tbl_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] tbl_pay [CAPACITY];
    bit                      tbl_live[CAPACITY];
    int                      tbl_used;

    table_result_t    pending_results[$];
    logic [KEY_W-1:0] key_pool[64];
    int               mismatch_count;
    bit               tx_idle_en;
    bit               rx_stall_en;
    int               rx_hold_cycles;

    keyed_table_lazy_delete_compact_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic table_result_t table_apply(input logic [CMD_W-1:0] c,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [PAYLOAD_BITS-1:0] p);
        table_result_t r;
        int hit;
        int i;
        int live;
        r = '0;
        hit = -1;
        if (c <= CMD_UPDATE)
        begin
            for (i = 0; i < tbl_used && hit < 0; i++)
            begin
                if (tbl_live[i] && tbl_key[i] == k)
                    hit = i;
            end
        end
        if (hit >= 0)
        begin
            r.found = 1'b1;
            r.slot  = IDX_W'(hit);
        end
        case (c)
            CMD_INSERT:
            begin
                if (hit >= 0)
                    r.status = STAT_DUPLICATE;
                else if (tbl_used >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    tbl_key[tbl_used]  = k;
                    tbl_pay[tbl_used]  = p;
                    tbl_live[tbl_used] = 1'b1;
                    r.slot = IDX_W'(tbl_used);
                    tbl_used++;
                end
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                    tbl_live[hit] = 1'b0;
                else
                    r.status = STAT_NOT_FOUND;
            end
            CMD_LOOKUP:
            begin
                if (hit >= 0)
                    r.pay = tbl_pay[hit];
                else
                    r.status = STAT_NOT_FOUND;
            end
            CMD_UPDATE:
            begin
                if (hit >= 0)
                    tbl_pay[hit] = p;
                else
                    r.status = STAT_NOT_FOUND;
            end
            CMD_COMPACT:
            begin
                live = 0;
                for (i = 0; i < tbl_used; i++)
                begin
                    if (tbl_live[i])
                    begin
                        tbl_key[live]  = tbl_key[i];
                        tbl_pay[live]  = tbl_pay[i];
                        tbl_live[live] = 1'b1;
                        live++;
                    end
                end
                for (i = live; i < tbl_used; i++)
                    tbl_live[i] = 1'b0;
                tbl_used = live;
            end
            default:
            begin
            end
        endcase
        r.used = CNT_W'(tbl_used);
        return r;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                             input logic [PAYLOAD_BITS-1:0] p);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tdata  <= {{(S_DATA_W - S_RAW_W){1'b0}}, p, k, c};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(table_apply(c, k, p));
    endtask

    task automatic wait_results_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    function automatic logic [PAYLOAD_BITS-1:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    task automatic fill_key_pool();
        int i;
        for (i = 0; i < 64; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = '0;
        key_pool[3] = '1;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int pool_n);
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 32)
            return CMD_INSERT;
        if (r < 47)
            return CMD_REMOVE;
        if (r < 70)
            return CMD_LOOKUP;
        if (r < 86)
            return CMD_UPDATE;
        if (r < 95)
            return CMD_COMPACT;
        return CMD_W'($urandom_range(CMD_COMPACT + 1, (1 << CMD_W) - 1));
    endfunction

    task automatic test_directed_ops();
        int i;
        send_item(CMD_LOOKUP, 32'h0000_0000, '0);
        send_item(CMD_INSERT, 32'h8000_0000, '1);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, '0);
        send_item(CMD_INSERT, 32'h0000_0000, 64'hA5A5_5A5A_F00F_0FF0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 64'h1234);
        send_item(CMD_LOOKUP, 32'h8000_0000, '0);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
        send_item(CMD_LOOKUP, 32'h1234_5678, '0);
        send_item(CMD_UPDATE, 32'h7FFF_FFFF, 64'h5A5A_A5A5_0FF0_F00F);
        send_item(CMD_UPDATE, 32'h0000_0001, '1);
        send_item(CMD_LOOKUP, 32'h7FFF_FFFF, '0);
        send_item(CMD_REMOVE, 32'h0000_0000, '0);
        send_item(CMD_REMOVE, 32'h0000_0000, '0);
        send_item(CMD_LOOKUP, 32'h0000_0000, '0);
        send_item(CMD_UPDATE, 32'h0000_0000, '1);
        send_item(CMD_INSERT, 32'h0000_0000, '1);
        send_item(CMD_REMOVE, 32'h8000_0000, '0);
        send_item(CMD_COMPACT, '0, '0);
        send_item(CMD_LOOKUP, 32'h0000_0000, '0);
        for (i = CMD_COMPACT + 1; i < (1 << CMD_W); i++)
            send_item(CMD_W'(i), '1, '1);
        send_item(CMD_COMPACT, '1, '1);
    endtask

    task automatic test_fill_and_full();
        int i;
        while (tbl_used < CAPACITY)
            send_item(CMD_INSERT, $urandom, rand_payload());
        send_item(CMD_INSERT, $urandom, rand_payload());
        send_item(CMD_INSERT, tbl_key[CAPACITY - 1], rand_payload());
        send_item(CMD_LOOKUP, tbl_key[CAPACITY - 1], '0);
        for (i = 0; i < 3; i++)
            send_item(CMD_REMOVE, tbl_key[i * 20], '0);
        send_item(CMD_INSERT, $urandom, rand_payload());
        send_item(CMD_LOOKUP, tbl_key[20], '0);
        send_item(CMD_COMPACT, $urandom, rand_payload());
        send_item(CMD_INSERT, $urandom, rand_payload());
        send_item(CMD_LOOKUP, tbl_key[tbl_used - 1], '0);
        send_item(CMD_UPDATE, tbl_key[tbl_used - 1], rand_payload());
    endtask

    task automatic test_output_backpressure();
        int i;
        fill_key_pool();
        rx_hold_cycles = 400;
        for (i = 0; i < 12; i++)
            send_item(pick_cmd(), pick_key(6), rand_payload());
        wait_results_drained();
    endtask

    task automatic test_random_mix();
        int phase;
        int i;
        int pool_n;
        for (phase = 0; phase < 11; phase++)
        begin
            fill_key_pool();
            case (phase % 4)
                0: pool_n = 3;
                1: pool_n = 8;
                2: pool_n = 20;
                default: pool_n = 60;
            endcase
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            for (i = 0; i < 150; i++)
                send_item(pick_cmd(), pick_key(pool_n), rand_payload());
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    task automatic test_full_rate();
        int i;
        fill_key_pool();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        for (i = 0; i < 200; i++)
            send_item(pick_cmd(), pick_key(8), rand_payload());
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        table_result_t got;
        table_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[M_RAW_W-1:0];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected item, expected none actual %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("found", 64'(want.found), 64'(got.found));
                check_field("slot_index", 64'(want.slot), 64'(got.slot));
                check_field("payload_out", want.pay, got.pay);
                check_field("used_count", 64'(want.used), 64'(got.used));
            end
        end
    end

    initial
    begin : rx_side
        int n;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_stall_en && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        #20_000_000;
        $display("** keyed_table_lazy_delete_compact_top: FAILED **");
        $finish;
    end

    initial
    begin : main_seq
        int i;
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        mismatch_count = 0;
        rx_hold_cycles = 0;
        tx_idle_en     = 1'b1;
        rx_stall_en    = 1'b1;
        tbl_used       = 0;
        for (i = 0; i < CAPACITY; i++)
        begin
            tbl_key[i]  = '0;
            tbl_pay[i]  = '0;
            tbl_live[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_fill_and_full();
        test_output_backpressure();
        test_random_mix();
        test_full_rate();
        wait_results_drained();
        repeat (100) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d items missing, expected %h actual none", $time,
                     pending_results.size(), pending_results[0]);
        end
        if (mismatch_count == 0)
            $display("** keyed_table_lazy_delete_compact_top: PASSED **");
        else
            $display("** keyed_table_lazy_delete_compact_top: FAILED **");
        $finish;
    end

endmodule

### keyed_table_lazy_delete_compact_top.f
hdl/kt_pkg.sv
hdl/kt_store.sv
hdl/keyed_table_lazy_delete_compact_top.sv
tb/tb_keyed_table_lazy_delete_compact_top.sv
